// ===== sv/dcd_pkg.sv =====
// ---------------------------------------------------------------------------
// dcd_pkg: shared types and constants of the directed cycle detector
// Sizes of the node and edge stores, link encoding, control/status bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcd_pkg;

  localparam int unsigned MAX_NODES = 256;
  localparam int unsigned MAX_EDGES = 1024;

  localparam int unsigned NODE_W  = $clog2(MAX_NODES);  // node index
  localparam int unsigned EDGE_W  = $clog2(MAX_EDGES);  // edge store address
  localparam int unsigned LINK_W  = EDGE_W + 1;         // edge index or empty marker
  localparam int unsigned CNT_W   = NODE_W + 1;         // node count
  localparam int unsigned DEPTH_W = NODE_W + 1;         // search stack depth

  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(MAX_EDGES);

  // controller -> datapath
  typedef struct packed {
    logic cap_in;          // capture input fields
    logic head_rd_src;     // read chain head at incoming source node
    logic load_commit;     // store edge, relink chain head
    logic set_drop;        // reject edge
    logic chk_init;        // reset check counters
    logic clr_step;        // clear one mark entry
    logic start_inc;       // next start node
    logic root;            // open search at start node
    logic head_to_cursor;  // cursor <= chain head read data
    logic edge_take;       // cursor <= next link, latch target
    logic mark_rd_tgt;     // mark read at edge target (else start node)
    logic push;            // descend into target node
    logic pop;             // leave top node
    logic stack_to_top;    // restore top from stack read data
    logic set_found;       // back edge seen
    logic out_load;        // load result register
  } dcd_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic ld_ok;
    logic n_zero;
    logic clr_last;
    logic start_end;
    logic mark_seen;
    logic mark_onpath;
    logic cursor_end;
    logic depth_last;
    logic depth_full;
    logic tgt_out;
    logic out_free;
  } dcd_sts_t;

endpackage : dcd_pkg

`default_nettype wire

// ===== sv/dcd_ctrl.sv =====
// ---------------------------------------------------------------------------
// dcd_ctrl: sequencer of the directed cycle detector
// Runs edge loads, the mark clear sweep and the stack-based depth-first walk.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcd_ctrl
  import dcd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     cmd_i,
  input  wire dcd_sts_t sts_i,
  output logic          in_stall_o,
  output dcd_ctl_t      ctl_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOAD    = 4'd1;
  localparam logic [3:0] S_CLEAR   = 4'd2;
  localparam logic [3:0] S_OUT_RD  = 4'd3;
  localparam logic [3:0] S_OUT_CHK = 4'd4;
  localparam logic [3:0] S_HEAD    = 4'd5;
  localparam logic [3:0] S_EDGE    = 4'd6;
  localparam logic [3:0] S_EDGE_WT = 4'd7;
  localparam logic [3:0] S_MARK    = 4'd8;
  localparam logic [3:0] S_POP     = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.cap_in = 1'b1;
          if (cmd_i) begin
            ctl_o.chk_init = 1'b1;
            state_d        = S_CLEAR;
          end else begin
            ctl_o.head_rd_src = 1'b1;
            state_d           = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (sts_i.ld_ok) begin
          ctl_o.load_commit = 1'b1;
        end else begin
          ctl_o.set_drop = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_CLEAR: begin
        if (sts_i.n_zero) begin
          state_d = S_FIN;
        end else begin
          ctl_o.clr_step = 1'b1;
          if (sts_i.clr_last) state_d = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        if (sts_i.start_end) begin
          state_d = S_FIN;
        end else begin
          state_d = S_OUT_CHK;
        end
      end
      S_OUT_CHK: begin
        if (sts_i.mark_seen) begin
          ctl_o.start_inc = 1'b1;
          state_d         = S_OUT_RD;
        end else begin
          ctl_o.root = 1'b1;
          state_d    = S_HEAD;
        end
      end
      S_HEAD: begin
        ctl_o.head_to_cursor = 1'b1;
        state_d              = S_EDGE;
      end
      S_EDGE: begin
        if (sts_i.cursor_end) begin
          ctl_o.pop = 1'b1;
          if (sts_i.depth_last) begin
            ctl_o.start_inc = 1'b1;
            state_d         = S_OUT_RD;
          end else begin
            state_d = S_POP;
          end
        end else begin
          state_d = S_EDGE_WT;
        end
      end
      S_EDGE_WT: begin
        ctl_o.edge_take = 1'b1;
        if (sts_i.tgt_out) begin
          state_d = S_EDGE;
        end else begin
          ctl_o.mark_rd_tgt = 1'b1;
          state_d           = S_MARK;
        end
      end
      S_MARK: begin
        priority if (sts_i.mark_onpath) begin
          ctl_o.set_found = 1'b1;
          state_d         = S_FIN;
        end else if (!sts_i.mark_seen && !sts_i.depth_full) begin
          ctl_o.push = 1'b1;
          state_d    = S_HEAD;
        end else begin
          state_d = S_EDGE;
        end
      end
      S_POP: begin
        ctl_o.stack_to_top = 1'b1;
        state_d            = S_EDGE;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : dcd_ctrl

`default_nettype wire

// ===== sv/dcd_dpath.sv =====
// ---------------------------------------------------------------------------
// dcd_dpath: datapath of the directed cycle detector
// Chain heads, edge store, marks, search stack, counters and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcd_dpath
  import dcd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CNT_W-1:0]  cfg_wdata_i,
  input  wire logic [NODE_W-1:0] source_node_i,
  input  wire logic [NODE_W-1:0] target_node_i,
  input  wire logic              out_stall_i,
  input  wire dcd_ctl_t          ctl_i,
  output dcd_sts_t               sts_o,
  output logic                   out_valid_o,
  output logic                   has_cycle_o,
  output logic                   edges_dropped_o
);

  localparam int unsigned EREC_W = LINK_W + NODE_W;  // {next link, target}
  localparam int unsigned SREC_W = NODE_W + LINK_W;  // {node, cursor}

  // memories
  logic [LINK_W-1:0] head_mem  [MAX_NODES];
  logic [EREC_W-1:0] edge_mem  [MAX_EDGES];
  logic [1:0]        mark_mem  [MAX_NODES];  // {seen, on path}
  logic [SREC_W-1:0] stack_mem [MAX_NODES];
  logic [MAX_NODES-1:0] head_vld_q;

  // control registers
  logic [CNT_W-1:0]   node_count_q;
  logic [LINK_W-1:0]  total_q;
  logic               drop_q;
  logic [DEPTH_W-1:0] depth_q;
  logic               out_valid_q;

  // payload registers
  logic [NODE_W-1:0]  src_q, dst_q, tgt_q, clr_idx_q, top_node_q;
  logic [CNT_W-1:0]   start_q;
  logic [LINK_W-1:0]  top_cursor_q;
  logic               found_q, has_cycle_q, dropped_q;
  logic [LINK_W-1:0]  head_rdata_q;
  logic               head_vld_rd_q;
  logic [EREC_W-1:0]  edge_rdata_q;
  logic [1:0]         mark_rdata_q;
  logic [SREC_W-1:0]  stack_rdata_q;

  logic [CNT_W-1:0]   n_eff;
  logic [LINK_W-1:0]  head_eff;
  logic [NODE_W-1:0]  head_raddr, mark_raddr, mark_waddr;
  logic [NODE_W-1:0]  edge_tgt;
  logic [LINK_W-1:0]  edge_nxt;
  logic               mark_we;
  logic [1:0]         mark_wdata;
  logic [DEPTH_W-1:0] stk_waddr, stk_raddr;

  assign n_eff    = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
  assign head_eff = head_vld_rd_q ? head_rdata_q : EMPTY_LINK;
  assign edge_tgt = edge_rdata_q[NODE_W-1:0];
  assign edge_nxt = edge_rdata_q[EREC_W-1:NODE_W];
  assign stk_waddr = depth_q - DEPTH_W'(1);
  assign stk_raddr = depth_q - DEPTH_W'(2);

  always_comb begin
    priority if (ctl_i.head_rd_src) head_raddr = source_node_i;
    else if (ctl_i.root)            head_raddr = start_q[NODE_W-1:0];
    else                            head_raddr = tgt_q;
  end

  assign mark_raddr = ctl_i.mark_rd_tgt ? edge_tgt : start_q[NODE_W-1:0];

  always_comb begin
    mark_we    = 1'b1;
    mark_waddr = top_node_q;
    mark_wdata = 2'b10;
    priority if (ctl_i.clr_step) begin
      mark_waddr = clr_idx_q;
      mark_wdata = 2'b00;
    end else if (ctl_i.root) begin
      mark_waddr = start_q[NODE_W-1:0];
      mark_wdata = 2'b11;
    end else if (ctl_i.push) begin
      mark_waddr = tgt_q;
      mark_wdata = 2'b11;
    end else if (ctl_i.pop) begin
      mark_waddr = top_node_q;
      mark_wdata = 2'b10;
    end else begin
      mark_we = 1'b0;
    end
  end

  // status
  assign sts_o.ld_ok       = ({1'b0, src_q} < n_eff) && ({1'b0, dst_q} < n_eff) &&
                             (total_q < LINK_W'(MAX_EDGES));
  assign sts_o.n_zero      = (n_eff == '0);
  assign sts_o.clr_last    = ({1'b0, clr_idx_q} == (n_eff - CNT_W'(1)));
  assign sts_o.start_end   = (start_q == n_eff);
  assign sts_o.mark_seen   = mark_rdata_q[1];
  assign sts_o.mark_onpath = mark_rdata_q[0];
  assign sts_o.cursor_end  = (top_cursor_q >= total_q);
  assign sts_o.depth_last  = (depth_q == DEPTH_W'(1));
  assign sts_o.depth_full  = (depth_q == DEPTH_W'(MAX_NODES));
  assign sts_o.tgt_out     = ({1'b0, edge_tgt} >= n_eff);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  // memory ports
  always_ff @(posedge clk_i) begin
    head_rdata_q  <= head_mem[head_raddr];
    head_vld_rd_q <= head_vld_q[head_raddr];
    if (ctl_i.load_commit) head_mem[src_q] <= total_q;
  end

  always_ff @(posedge clk_i) begin
    edge_rdata_q <= edge_mem[top_cursor_q[EDGE_W-1:0]];
    if (ctl_i.load_commit) edge_mem[total_q[EDGE_W-1:0]] <= {head_eff, dst_q};
  end

  always_ff @(posedge clk_i) begin
    mark_rdata_q <= mark_mem[mark_raddr];
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
  end

  always_ff @(posedge clk_i) begin
    stack_rdata_q <= stack_mem[stk_raddr[NODE_W-1:0]];
    if (ctl_i.push) stack_mem[stk_waddr[NODE_W-1:0]] <= {top_node_q, top_cursor_q};
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(MAX_NODES);
      total_q      <= '0;
      drop_q       <= 1'b0;
      depth_q      <= '0;
      out_valid_q  <= 1'b0;
      head_vld_q   <= '0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      if (ctl_i.load_commit) begin
        total_q           <= total_q + LINK_W'(1);
        head_vld_q[src_q] <= 1'b1;
      end
      if (ctl_i.set_drop) drop_q <= 1'b1;
      priority if (ctl_i.root) depth_q <= DEPTH_W'(1);
      else if (ctl_i.push)     depth_q <= depth_q + DEPTH_W'(1);
      else if (ctl_i.pop)      depth_q <= depth_q - DEPTH_W'(1);
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_in) begin
      src_q <= source_node_i;
      dst_q <= target_node_i;
    end
    if (ctl_i.chk_init) begin
      clr_idx_q <= '0;
      start_q   <= '0;
      found_q   <= 1'b0;
    end
    if (ctl_i.clr_step)  clr_idx_q <= clr_idx_q + NODE_W'(1);
    if (ctl_i.start_inc) start_q   <= start_q + CNT_W'(1);
    if (ctl_i.set_found) found_q   <= 1'b1;
    if (ctl_i.root)      top_node_q <= start_q[NODE_W-1:0];
    if (ctl_i.push)      top_node_q <= tgt_q;
    if (ctl_i.head_to_cursor) top_cursor_q <= head_eff;
    if (ctl_i.edge_take) begin
      top_cursor_q <= edge_nxt;
      tgt_q        <= edge_tgt;
    end
    if (ctl_i.stack_to_top) begin
      top_node_q   <= stack_rdata_q[SREC_W-1:LINK_W];
      top_cursor_q <= stack_rdata_q[LINK_W-1:0];
    end
    if (ctl_i.out_load) begin
      has_cycle_q <= found_q;
      dropped_q   <= drop_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign has_cycle_o     = has_cycle_q;
  assign edges_dropped_o = dropped_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= LINK_W'(MAX_EDGES))
    else $error("edge total beyond store size");

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load_commit |-> (total_q < LINK_W'(MAX_EDGES)) && ({1'b0, src_q} < n_eff))
    else $error("edge stored without room or with bad source");

  a_push_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> (depth_q != '0) && (depth_q < DEPTH_W'(MAX_NODES)))
    else $error("push on empty or full stack");

  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten before transfer");

endmodule : dcd_dpath

`default_nettype wire

// ===== sv/directed_cycle_detector.sv =====
// ---------------------------------------------------------------------------
// directed_cycle_detector: directed graph cycle check by depth-first search
// Loads edges into per-node chains and answers cycle checks on demand.
// ---------------------------------------------------------------------------
// An edge load (cmd 0) does one chain-head read, then one store write if kept.
// It produces no result. Edges with an endpoint at or above node_count, or
// arriving when the edge store is full, are dropped and set a sticky flag that
// every check result reports. A check (cmd 1) first clears the node marks
// of all active nodes, then walks the graph from each unvisited node in
// index order, and stops early at the first back edge. node_count above 256
// acts as 256. Write node_count only while no item is in progress.
`timescale 1ns / 1ps
`default_nettype none

module directed_cycle_detector
  import dcd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CNT_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              cmd_i,
  input  wire logic [NODE_W-1:0] source_node_i,
  input  wire logic [NODE_W-1:0] target_node_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   has_cycle_o,
  output logic                   edges_dropped_o
);

  dcd_ctl_t ctl;
  dcd_sts_t sts;

  dcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  dcd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .source_node_i   (source_node_i),
    .target_node_i   (target_node_i),
    .out_stall_i     (out_stall_i),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .has_cycle_o     (has_cycle_o),
    .edges_dropped_o (edges_dropped_o)
  );

endmodule : directed_cycle_detector

`default_nettype wire

// ===== test/directed_cycle_detector_tb.sv =====
// ---------------------------------------------------------------------------
// directed_cycle_detector_tb: self-checking bench for the cycle detector
// Loads edges and issues cycle checks under random input gaps and output
// stalls. A local graph model predicts each check result, and every result
// transfer is compared against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module directed_cycle_detector_tb;
  import dcd_pkg::*;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam int unsigned CYCLE_LIMIT  = 20_000_000;
  localparam int unsigned PHASE_ITEMS  = 115;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic has_cycle;
    logic dropped;
  } verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              cmd_i = CMD_EDGE;
  logic [NODE_W-1:0] source_node_i = '0;
  logic [NODE_W-1:0] target_node_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  logic              has_cycle_o;
  logic              edges_dropped_o;

  directed_cycle_detector uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .source_node_i  (source_node_i),
    .target_node_i  (target_node_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .has_cycle_o    (has_cycle_o),
    .edges_dropped_o(edges_dropped_o)
  );

  always #4 clk_i = ~clk_i;

  // graph model
  logic [LINK_W-1:0] head_q [MAX_NODES];
  logic [LINK_W-1:0] link_q [MAX_EDGES];
  logic [NODE_W-1:0] dest_q [MAX_EDGES];
  int unsigned       edge_total = 0;
  bit                dropped_seen = 1'b0;
  logic [CNT_W-1:0]  nodes_cfg = CNT_W'(MAX_NODES);

  verdict_t    verdict_q [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned sent_count = 0;
  int unsigned hold_cnt = 0;
  bit          steady = 1'b0;

  function automatic int unsigned live_nodes();
    return (nodes_cfg > MAX_NODES) ? MAX_NODES : int'(nodes_cfg);
  endfunction

  function automatic void store_edge(input logic [NODE_W-1:0] src, dst);
    if (src >= live_nodes() || dst >= live_nodes() || edge_total >= MAX_EDGES) begin
      dropped_seen = 1'b1;
    end else begin
      dest_q[edge_total] = dst;
      link_q[edge_total] = head_q[src];
      head_q[src] = LINK_W'(edge_total);
      edge_total++;
    end
  endfunction

  // depth-first walk from every unvisited node; a hit on the current path is a cycle
  function automatic bit graph_has_cycle();
    bit                seen [MAX_NODES];
    bit                on_path [MAX_NODES];
    int unsigned       trail_node [MAX_NODES];
    logic [LINK_W-1:0] trail_link [MAX_NODES];
    int unsigned       n, depth, u, t;
    logic [LINK_W-1:0] e;
    n = live_nodes();
    for (int i = 0; i < MAX_NODES; i++) begin
      seen[i] = 1'b0;
      on_path[i] = 1'b0;
    end
    for (int unsigned s = 0; s < n; s++) begin
      if (!seen[s]) begin
        depth = 1;
        trail_node[0] = s;
        trail_link[0] = head_q[s];
        seen[s] = 1'b1;
        on_path[s] = 1'b1;
        while (depth > 0) begin
          u = trail_node[depth-1];
          e = trail_link[depth-1];
          if (e >= edge_total) begin
            on_path[u] = 1'b0;
            depth--;
          end else begin
            t = dest_q[e];
            trail_link[depth-1] = link_q[e];
            if (t < n) begin
              if (on_path[t]) return 1'b1;
              if (!seen[t] && depth < MAX_NODES) begin
                seen[t] = 1'b1;
                on_path[t] = 1'b1;
                trail_node[depth] = t;
                trail_link[depth] = head_q[t];
                depth++;
              end
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // one input transfer; valid stays high across back-to-back items
  task automatic send_item(input logic cmd, input int unsigned src, input int unsigned dst);
    int unsigned gap;
    verdict_t    expect_v;
    if (sent_count % 40 == 0) steady = ($urandom_range(0, 3) == 0);
    sent_count++;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    source_node_i <= NODE_W'(src);
    target_node_i <= NODE_W'(dst);
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CMD_CHECK) begin
      expect_v.has_cycle = graph_has_cycle();
      expect_v.dropped   = dropped_seen;
      verdict_q.insert(verdict_q.size(), expect_v);
    end else begin
      store_edge(NODE_W'(src), NODE_W'(dst));
    end
  endtask

  task automatic add_edge(input int unsigned src, input int unsigned dst);
    send_item(CMD_EDGE, src, dst);
  endtask

  task automatic run_check();
    send_item(CMD_CHECK, 0, 0);
  endtask

  // drain all pending results, then give a trailing edge load time to land
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(input int unsigned value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_W'(value);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    nodes_cfg = CNT_W'(value);
  endtask

  task automatic test_empty_graph();
    run_check();
  endtask

  task automatic test_acyclic_load();
    write_node_count(MAX_NODES);
    add_edge(0, 255);
    add_edge(0, 1);
    add_edge(1, 2);
    run_check();
  endtask

  // cycles kept on the top nodes so that lowering the count hides them
  task automatic test_high_cycle();
    add_edge(254, 253);
    add_edge(253, 254);
    add_edge(255, 255);
    run_check();
  endtask

  task automatic test_count_lowered();
    write_node_count(253);
    run_check();
  endtask

  task automatic test_out_of_range();
    add_edge(253, 0);
    add_edge(0, 253);
    run_check();
  endtask

  task automatic test_zero_nodes();
    write_node_count(0);
    add_edge(0, 0);
    run_check();
  endtask

  task automatic test_count_above_max();
    write_node_count(511);
    run_check();
    write_node_count(300);
    add_edge(255, 254);
    run_check();
    write_node_count(MAX_NODES);
    run_check();
  endtask

  task automatic test_one_node();
    write_node_count(1);
    add_edge(0, 1);
    run_check();
  endtask

  // Phases with falling node counts. Forward edges never close a loop; back
  // edges are kept to the band between this count and the next one, so a
  // later phase no longer sees them.
  task automatic test_random_graphs();
    int unsigned span [11] = '{250, 200, 150, 100, 64, 32, 16, 8, 4, 2, 1};
    int unsigned n, lo, r, a, b, tmp;
    for (int k = 0; k < 10; k++) begin
      n  = span[k];
      lo = span[k+1];
      write_node_count(n);
      for (int unsigned j = 0; j < PHASE_ITEMS; j++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          run_check();
        end else if (r < 20) begin
          if ($urandom_range(0, 1)) add_edge($urandom_range(n, 255), $urandom_range(0, 255));
          else add_edge($urandom_range(0, 255), $urandom_range(n, 255));
        end else if (j > PHASE_ITEMS / 2 && r < 28) begin
          a = $urandom_range(lo, n - 1);
          b = $urandom_range(lo, a);
          add_edge(a, b);
        end else begin
          a = $urandom_range(0, n - 1);
          b = $urandom_range(0, n - 1);
          if (a > b) begin
            tmp = a;
            a = b;
            b = tmp;
          end
          if (a == b) begin
            if (b < n - 1) b++;
            else a--;
          end
          add_edge(a, b);
        end
      end
      run_check();
    end
  endtask

  task automatic test_store_full();
    int unsigned a;
    write_node_count(4);
    while (edge_total < MAX_EDGES) begin
      a = $urandom_range(0, 2);
      add_edge(a, $urandom_range(a + 1, 3));
    end
    add_edge(0, 1);
    add_edge(2, 3);
    add_edge(1, 3);
    run_check();
    write_node_count(MAX_NODES);
    run_check();
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: compare each transfer, then draw the next stall length
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: has_cycle=%0d edges_dropped=%0d",
                   has_cycle_o, edges_dropped_o);
      end else begin
        want = verdict_q.pop_front();
        if (want.has_cycle !== has_cycle_o || want.dropped !== edges_dropped_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: has_cycle exp %0d got %0d, edges_dropped exp %0d got %0d",
                     want.has_cycle, has_cycle_o, want.dropped, edges_dropped_o);
        end
      end
      hold_cnt = steady ? 0 : $urandom_range(0, 18);
    end else if (out_valid_o && hold_cnt != 0) begin
      hold_cnt--;
    end
    out_stall_i <= (hold_cnt != 0);
  end

  initial begin
    for (int i = 0; i < MAX_NODES; i++) head_q[i] = EMPTY_LINK;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_graph();
    test_acyclic_load();
    test_high_cycle();
    test_count_lowered();
    test_out_of_range();
    test_zero_nodes();
    test_count_above_max();
    test_one_node();
    test_random_graphs();
    test_store_full();

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
